[hdl/fx2dec_pkg.sv]
// Shared constants and types of the 16.16 fixed-point to decimal text converter.
// No dependencies; the ALU, the top level, the checker and the testbench top refer to this package.
package fx2dec_pkg;

  localparam int BUFFER_BYTES = 24;
  localparam int TEXT_DEPTH   = 13;
  localparam int TEXT_AW      = $clog2(TEXT_DEPTH);
  localparam int MAX_FRACTION = 6;
  localparam int INT_DIGITS   = 6;
  localparam int IPART_W      = 17;
  localparam int FPART_W      = 16;
  localparam int DIGIT_W      = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_POINT = 8'h2e;

  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
  localparam logic [DIGIT_W-1:0] ROUND_HALF = 4'd5;

  typedef enum logic [1:0] {
    ALU_MUL10,
    ALU_DIV10,
    ALU_INC
  } alu_op_e;

  typedef struct packed {
    alu_op_e              op;
    logic [IPART_W-1:0]   operand;
  } alu_req_t;

  typedef struct packed {
    logic [IPART_W-1:0]   result;
    logic [DIGIT_W-1:0]   digit;
  } alu_rsp_t;

endpackage

[hdl/fx2dec_in_if.sv]
// Request channel of the converter: valid/ready handshake and the input word.
// Depends on nothing.
interface fx2dec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        signed_mode;
  logic [2:0]  fraction_digits;

  modport source (output valid, value, signed_mode, fraction_digits, input ready);
  modport sink   (input valid, value, signed_mode, fraction_digits, output ready);
endinterface

[hdl/fx2dec_out_if.sv]
// Result channel of the converter: valid/ready handshake and one text character.
// Depends on nothing.
interface fx2dec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;
  logic       error;

  modport source (output valid, character, last_char, error, input ready);
  modport sink   (input valid, character, last_char, error, output ready);
endinterface

[hdl/fx2dec_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fx2dec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fx2dec_alu.sv]
// Shared arithmetic unit: times ten on the fraction, divide by ten with
// remainder on the integer part, and increment. Uses fx2dec_pkg.
module fx2dec_alu (
  input  fx2dec_pkg::alu_req_t req_i,
  output fx2dec_pkg::alu_rsp_t rsp_o
);

  logic [19:0] prod10;
  logic [29:0] recip;
  logic [13:0] quot0;
  logic [16:0] quot0x10;
  logic [16:0] rem0;
  logic [16:0] quot;
  logic [16:0] rem;

  always_comb begin
    prod10   = 20'({req_i.operand[15:0], 3'b000}) + 20'({req_i.operand[15:0], 1'b0});
    // The reciprocal underestimates by less than one, so one correction suffices.
    recip    = 30'(req_i.operand) * 30'(13'd6553);
    quot0    = recip[29:16];
    quot0x10 = 17'({quot0, 3'b000}) + 17'({quot0, 1'b0});
    rem0     = req_i.operand - quot0x10;
    if (rem0 >= 17'd10) begin
      quot = 17'(quot0) + 17'd1;
      rem  = rem0 - 17'd10;
    end else begin
      quot = 17'(quot0);
      rem  = rem0;
    end
    unique case (req_i.op)
      fx2dec_pkg::ALU_MUL10: begin
        rsp_o.result = 17'(prod10[15:0]);
        rsp_o.digit  = prod10[19:16];
      end
      fx2dec_pkg::ALU_DIV10: begin
        rsp_o.result = quot;
        rsp_o.digit  = rem[3:0];
      end
      fx2dec_pkg::ALU_INC: begin
        rsp_o.result = req_i.operand + 17'd1;
        rsp_o.digit  = '0;
      end
      default: begin
        rsp_o.result = '0;
        rsp_o.digit  = '0;
      end
    endcase
  end

endmodule

[hdl/fixed_16_16_to_decimal_ascii.sv]
// Top level of the 16.16 fixed-point to decimal text converter.
// Uses fx2dec_pkg, fx2dec_in_if, fx2dec_out_if, fx2dec_alu and fx2dec_ram.
//
// One request is taken at a time and the input is not ready until its text
// has been handed to the output register. The shared times-ten and
// divide-by-ten unit produces one digit per cycle, rounding and trimming walk
// the fraction digits one per cycle, and the text is written into the text
// RAM and read back through its single read port, one character per cycle
// while the output is not stalled. An invalid digit count leads through the
// error state to the error result in the output register.
module fixed_16_16_to_decimal_ascii (
  input  logic          clk_i,
  input  logic          rst_ni,
  fx2dec_in_if.sink     in_i,
  fx2dec_out_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAC,
    ST_ROUND,
    ST_TRIM,
    ST_INTG,
    ST_CHECK,
    ST_BUILD,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_ERR
  } state_e;

  state_e state_q;

  logic [fx2dec_pkg::IPART_W-1:0] ipart_q;
  logic [fx2dec_pkg::FPART_W-1:0] fpart_q;
  logic [fx2dec_pkg::DIGIT_W-1:0] frac_q [fx2dec_pkg::MAX_FRACTION];
  logic [fx2dec_pkg::DIGIT_W-1:0] idig_q [fx2dec_pkg::INT_DIGITS];
  logic [2:0] ndig_q;
  logic [2:0] k_q;
  logic [2:0] fcount_q;
  logic [2:0] icount_q;
  logic       neg_q;
  logic       carry_q;
  logic [fx2dec_pkg::TEXT_AW-1:0] pos_q;
  logic [fx2dec_pkg::TEXT_AW-1:0] ptr_q;
  logic [fx2dec_pkg::TEXT_AW-1:0] len_q;
  logic       ovalid_q;
  logic [7:0] ochar_q;
  logic       olast_q;
  logic       oerr_q;

  fx2dec_pkg::alu_req_t alu_req;
  fx2dec_pkg::alu_rsp_t alu_rsp;

  logic        accept;
  logic        in_neg;
  logic [31:0] in_mag;
  logic [2:0]  frac_idx;
  logic [fx2dec_pkg::DIGIT_W-1:0] frac_rd;
  logic [3:0]  bpos;
  logic [3:0]  idig_off;
  logic [3:0]  frac_off;
  logic [fx2dec_pkg::DIGIT_W-1:0] idig_rd;
  logic [7:0]  build_char;
  logic [4:0]  len_w;
  logic        len_bad;
  logic        out_free;
  logic        emit_last;
  logic        out_load;
  logic        ram_we;
  logic        ram_re;
  logic [fx2dec_pkg::TEXT_AW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;

  assign accept   = in_i.valid && in_i.ready;
  assign in_neg   = in_i.signed_mode && in_i.value[31];
  assign in_mag   = in_neg ? (~in_i.value + 32'd1) : in_i.value;
  assign out_free = !ovalid_q || out_o.ready;
  assign emit_last = (ptr_q == len_q - 1'b1);
  assign out_load = ((state_q == ST_EMIT_OUT) || (state_q == ST_ERR)) && out_free;

  always_comb begin
    unique case (state_q)
      ST_FRAC:  alu_req = '{op: fx2dec_pkg::ALU_MUL10, operand: 17'(fpart_q)};
      ST_INTG:  alu_req = '{op: fx2dec_pkg::ALU_DIV10, operand: ipart_q};
      ST_ROUND: alu_req = '{op: fx2dec_pkg::ALU_INC,   operand: ipart_q};
      default:  alu_req = '{op: fx2dec_pkg::ALU_MUL10, operand: 17'(fpart_q)};
    endcase
  end

  fx2dec_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Character position within the digits, past the sign.
  always_comb begin
    bpos     = 4'(pos_q) - 4'(neg_q);
    idig_off = 4'(icount_q) - 4'd1 - bpos;
    frac_off = bpos - 4'(icount_q) - 4'd1;
    unique case (state_q)
      ST_ROUND: frac_idx = k_q - 3'd1;
      ST_TRIM:  frac_idx = fcount_q - 3'd1;
      default:  frac_idx = frac_off[2:0];
    endcase
    frac_rd = (int'(frac_idx) < fx2dec_pkg::MAX_FRACTION) ? frac_q[frac_idx] : '0;
    idig_rd = (int'(idig_off[2:0]) < fx2dec_pkg::INT_DIGITS) ? idig_q[idig_off[2:0]] : '0;
    if (neg_q && (pos_q == '0)) begin
      build_char = fx2dec_pkg::CHAR_MINUS;
    end else if (bpos < 4'(icount_q)) begin
      build_char = fx2dec_pkg::CHAR_ZERO + 8'(idig_rd);
    end else if (bpos == 4'(icount_q)) begin
      build_char = fx2dec_pkg::CHAR_POINT;
    end else begin
      build_char = fx2dec_pkg::CHAR_ZERO + 8'(frac_rd);
    end
  end

  always_comb begin
    len_w = 5'(neg_q) + 5'(icount_q)
          + ((fcount_q != 3'd0) ? (5'(fcount_q) + 5'd1) : 5'd0);
    len_bad = (int'(len_w) >= fx2dec_pkg::BUFFER_BYTES)
           || (int'(len_w) > fx2dec_pkg::TEXT_DEPTH);
  end

  assign ram_we    = (state_q == ST_BUILD);
  assign ram_re    = (state_q == ST_EMIT_RD)
                  || ((state_q == ST_EMIT_OUT) && out_free && !emit_last);
  assign ram_raddr = (state_q == ST_EMIT_RD) ? ptr_q : ptr_q + 1'b1;

  fx2dec_ram #(
    .WIDTH (8),
    .DEPTH (fx2dec_pkg::TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (build_char),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ndig_q   <= '0;
      k_q      <= '0;
      fcount_q <= '0;
      icount_q <= '0;
      neg_q    <= 1'b0;
      carry_q  <= 1'b0;
      pos_q    <= '0;
      ptr_q    <= '0;
      len_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ndig_q <= in_i.fraction_digits;
            neg_q  <= in_neg;
            k_q    <= '0;
            if (int'(in_i.fraction_digits) > fx2dec_pkg::MAX_FRACTION) begin
              state_q <= ST_ERR;
            end else begin
              state_q <= ST_FRAC;
            end
          end
        end
        ST_FRAC: begin
          if (k_q < ndig_q) begin
            k_q <= k_q + 3'd1;
          end else begin
            carry_q <= (alu_rsp.digit >= fx2dec_pkg::ROUND_HALF);
            k_q     <= ndig_q;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (carry_q && (k_q != 3'd0)) begin
            k_q <= k_q - 3'd1;
            if (frac_rd != fx2dec_pkg::DIGIT_NINE) begin
              carry_q <= 1'b0;
            end
          end else begin
            fcount_q <= ndig_q;
            state_q  <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          if ((fcount_q != 3'd0) && (frac_rd == '0)) begin
            fcount_q <= fcount_q - 3'd1;
          end else begin
            if ((ipart_q == '0) && (fcount_q == 3'd0)) begin
              neg_q <= 1'b0;
            end
            icount_q <= '0;
            state_q  <= ST_INTG;
          end
        end
        ST_INTG: begin
          icount_q <= icount_q + 3'd1;
          if ((alu_rsp.result == '0)
              || (int'(icount_q) + 1 >= fx2dec_pkg::INT_DIGITS)) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          pos_q <= '0;
          ptr_q <= '0;
          if (len_bad) begin
            len_q   <= '0;
            state_q <= ST_ERR;
          end else begin
            len_q   <= len_w[fx2dec_pkg::TEXT_AW-1:0];
            state_q <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          if (pos_q == len_q - 1'b1) begin
            state_q <= ST_EMIT_RD;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (out_free) begin
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            len_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ipart_q <= {1'b0, in_mag[31:16]};
      fpart_q <= in_mag[15:0];
    end
    if ((state_q == ST_FRAC) && (k_q < ndig_q)) begin
      frac_q[k_q] <= alu_rsp.digit;
      fpart_q     <= alu_rsp.result[fx2dec_pkg::FPART_W-1:0];
    end
    if (state_q == ST_ROUND) begin
      if (carry_q && (k_q != 3'd0)) begin
        if (frac_rd == fx2dec_pkg::DIGIT_NINE) begin
          frac_q[frac_idx] <= '0;
        end else begin
          frac_q[frac_idx] <= frac_rd + 4'd1;
        end
      end else if (carry_q) begin
        ipart_q <= alu_rsp.result;
      end
    end
    if (state_q == ST_INTG) begin
      idig_q[icount_q] <= alu_rsp.digit;
      ipart_q          <= alu_rsp.result;
    end
    if (out_load) begin
      if (state_q == ST_ERR) begin
        ochar_q <= '0;
        olast_q <= 1'b1;
        oerr_q  <= 1'b1;
      end else begin
        ochar_q <= ram_rdata;
        olast_q <= emit_last;
        oerr_q  <= 1'b0;
      end
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.character = ochar_q;
  assign out_o.last_char = olast_q;
  assign out_o.error     = oerr_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input ready right after a request was taken");

  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error) |-> (out_o.last_char && (out_o.character == 8'd0)))
    else $error("error result without last mark or with a character");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.error) |->
      (((out_o.character >= fx2dec_pkg::CHAR_ZERO)
        && (out_o.character <= fx2dec_pkg::CHAR_ZERO + 8'd9))
       || (out_o.character == fx2dec_pkg::CHAR_MINUS)
       || (out_o.character == fx2dec_pkg::CHAR_POINT)))
    else $error("character outside the decimal text set");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_OUT) |-> (ptr_q < len_q))
    else $error("text read pointer beyond the text length");

endmodule

[verif/fx2dec_checker.sv]
// Passive checker of the 16.16 fixed-point to decimal text converter.
// Watches both channels, predicts the text of each request and compares it per character.
// Depends on fx2dec_pkg, fx2dec_in_if and fx2dec_out_if.
module fx2dec_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  fx2dec_in_if  num_if,
  fx2dec_out_if txt_if,
  output int    mismatch_count_o,
  output int    chars_pending_o
);

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       error;
  } text_char_t;

  text_char_t pending_chars[$];
  int         mismatch_count;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void predict_text(input logic [31:0] word, input logic sgn,
                                       input logic [2:0] ndig);
    logic [31:0] mag;
    logic [31:0] ipart;
    logic [31:0] fpart;
    logic [31:0] prod;
    logic [3:0]  frac [fx2dec_pkg::MAX_FRACTION];
    logic [3:0]  idig [fx2dec_pkg::INT_DIGITS];
    logic        neg;
    logic        carry;
    int          fcount;
    int          icount;
    int          len;
    int          k;
    logic [7:0]  line [$];

    if (ndig > fx2dec_pkg::MAX_FRACTION) begin
      pending_chars.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end

    neg = 1'b0;
    mag = word;
    if (sgn && word[31]) begin
      neg = 1'b1;
      mag = ~word + 32'd1;
    end

    ipart = mag >> 16;
    fpart = {16'h0000, mag[15:0]};
    for (k = 0; k < fx2dec_pkg::MAX_FRACTION; k++) frac[k] = 4'd0;
    for (k = 0; k < ndig; k++) begin
      prod    = fpart * 32'd10;
      frac[k] = prod[19:16];
      fpart   = {16'h0000, prod[15:0]};
    end

    prod  = fpart * 32'd10;
    carry = (prod[19:16] >= fx2dec_pkg::ROUND_HALF);
    k = ndig;
    while (carry && k != 0) begin
      k--;
      if (frac[k] == fx2dec_pkg::DIGIT_NINE) begin
        frac[k] = 4'd0;
      end else begin
        frac[k] = frac[k] + 4'd1;
        carry   = 1'b0;
      end
    end
    if (carry) ipart = ipart + 32'd1;

    fcount = ndig;
    while (fcount != 0 && frac[fcount-1] == 4'd0) fcount--;
    if (ipart == 0 && fcount == 0) neg = 1'b0;

    icount = 0;
    do begin
      idig[icount] = 4'(ipart % 10);
      ipart        = ipart / 10;
      icount++;
    end while (ipart != 0 && icount < fx2dec_pkg::INT_DIGITS);

    len = int'(neg) + icount + ((fcount != 0) ? 1 + fcount : 0);
    if (len >= fx2dec_pkg::BUFFER_BYTES || len > fx2dec_pkg::TEXT_DEPTH) begin
      pending_chars.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end

    if (neg) line.push_back(fx2dec_pkg::CHAR_MINUS);
    for (k = icount - 1; k >= 0; k--) line.push_back(fx2dec_pkg::CHAR_ZERO + 8'(idig[k]));
    if (fcount != 0) begin
      line.push_back(fx2dec_pkg::CHAR_POINT);
      for (k = 0; k < fcount; k++) line.push_back(fx2dec_pkg::CHAR_ZERO + 8'(frac[k]));
    end
    foreach (line[i]) pending_chars.push_back('{line[i], (i == line.size() - 1), 1'b0});
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (num_if.valid && num_if.ready)
        predict_text(num_if.value, num_if.signed_mode, num_if.fraction_digits);
      if (txt_if.valid && txt_if.ready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %02h", txt_if.character));
        end else begin
          want = pending_chars.pop_front();
          if (txt_if.character !== want.character)
            report_mismatch($sformatf("character %02h, want %02h",
                                      txt_if.character, want.character));
          if (txt_if.last_char !== want.last_char)
            report_mismatch($sformatf("last_char %0b, want %0b",
                                      txt_if.last_char, want.last_char));
          if (txt_if.error !== want.error)
            report_mismatch($sformatf("error %0b, want %0b", txt_if.error, want.error));
        end
      end
    end
    mismatch_count_o = mismatch_count;
    chars_pending_o  = pending_chars.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top of the 16.16 fixed-point to decimal text converter.
// Drives directed and random requests with random idling and gives the verdict.
// Depends on fx2dec_pkg, both channel interfaces, the converter and fx2dec_checker.
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatch_count;
  int   chars_pending;
  int   quiet_cycles;

  fx2dec_in_if  num_if ();
  fx2dec_out_if txt_if ();

  fixed_16_16_to_decimal_ascii u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_if),
    .out_o  (txt_if)
  );

  fx2dec_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .num_if           (num_if),
    .txt_if           (txt_if),
    .mismatch_count_o (mismatch_count),
    .chars_pending_o  (chars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    txt_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      txt_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((num_if.valid && num_if.ready) || (txt_if.valid && txt_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_number(input logic [31:0] word, input logic sgn, input logic [2:0] ndig);
    while ($urandom_range(99) < send_idle_pct) begin
      num_if.valid = 1'b0;
      @(negedge clk_i);
    end
    num_if.valid           = 1'b1;
    num_if.value           = word;
    num_if.signed_mode     = sgn;
    num_if.fraction_digits = ndig;
    @(posedge clk_i);
    while (!num_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return {16'($urandom_range(20)), 16'($urandom)};
      2:       return {16'hffff - 16'($urandom_range(3)), 16'($urandom)};
      3:       return {16'($urandom), 16'hffff - 16'($urandom_range(40))};
      4:       return {16'($urandom), 16'($urandom_range(40))};
      default: return {16'($urandom), 16'($urandom_range(10)) * 16'h1999};
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [2:0] ndig;
    for (int i = 0; i < count; i++) begin
      ndig = ($urandom_range(99) < 8) ? 3'd7 : 3'($urandom_range(fx2dec_pkg::MAX_FRACTION));
      send_number(random_word(), 1'($urandom), ndig);
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    num_if.valid           = 1'b0;
    num_if.value           = '0;
    num_if.signed_mode     = 1'b0;
    num_if.fraction_digits = '0;
    send_idle_pct          = 27;
    recv_idle_pct          = 49;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_number(32'h0000_0000, 1'b0, 3'd0);
    send_number(32'h0000_0000, 1'b1, 3'd6);
    send_number(32'h7fff_ffff, 1'b1, 3'd6);
    send_number(32'h8000_0000, 1'b1, 3'd0);
    send_number(32'h8000_0000, 1'b1, 3'd6);
    send_number(32'h8000_0000, 1'b0, 3'd6);
    send_number(32'hffff_ffff, 1'b0, 3'd6);
    send_number(32'hffff_ffff, 1'b0, 3'd0);
    send_number(32'hffff_ffff, 1'b1, 3'd6);
    send_number(32'hffff_ffff, 1'b1, 3'd0);
    send_number(32'hffff_8000, 1'b1, 3'd0);
    send_number(32'h0000_8000, 1'b0, 3'd0);
    send_number(32'h0000_ffff, 1'b0, 3'd3);
    send_number(32'h0009_ffff, 1'b0, 3'd4);
    send_number(32'h0001_8000, 1'b0, 3'd6);
    send_number(32'h000a_0000, 1'b0, 3'd3);
    send_number(32'hfff6_0000, 1'b1, 3'd2);
    send_number(32'h0003_243f, 1'b0, 3'd5);
    send_number(32'h0000_0001, 1'b0, 3'd1);
    send_number(32'h1234_5678, 1'b0, 3'd7);
    send_number(32'hffff_ffff, 1'b1, 3'd7);
    send_number(32'h0000_0000, 1'b0, 3'd7);

    send_random(86);
    send_idle_pct = 49;
    recv_idle_pct = 27;
    send_random(86);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(86);
    num_if.valid = 1'b0;

    while (chars_pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0 && chars_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
